>>> hw/rtl/msd_pkg.sv
// Shared types and constants for the minimum square-sum decomposer.
// No dependencies; used by msd_table_ram and min_square_sum_decomposer_top.
`default_nettype none

package msd_pkg;

    localparam int TermW  = 11;   // square_term width
    localparam int RootW  = 6;    // term_root width
    localparam int CountW = 3;    // term_count width
    localparam int EmitW  = 2;    // up to four terms per run

    localparam logic [CountW-1:0] CountNone = 3'd7;   // "no candidate yet"
    localparam logic [CountW-1:0] CountOne  = 3'd1;
    localparam logic [RootW-1:0]  RootOne   = 6'd1;
    localparam logic [EmitW-1:0]  EmitLast  = 2'd3;

    // One table entry: least count and the root of the last square term.
    typedef struct packed {
        logic [CountW-1:0] count;
        logic [RootW-1:0]  root;
    } t_entry;

    typedef enum logic [5:0] {
        StIdle      = 6'b000001,
        StFillStart = 6'b000010,
        StFill      = 6'b000100,
        StFillWr    = 6'b001000,
        StWalkRd    = 6'b010000,
        StWalkOut   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/min_square_sum_decomposer_top.sv
// Minimum square-sum decomposer. Each input transaction carries a target n;
// the block answers with the fewest perfect squares that sum to n, one output
// transaction per square term (largest-index term first along the stored
// chain), each tagged with its root, the total count and a last-term flag.
// A target of zero produces no output; targets above the table limit
// saturate to it. Results come from a single table memory holding, for every
// value v, the least count and the root of the last square term; the
// table is filled lazily and kept between transactions. A target not
// yet in the table extends it value by value, each new non-square value v
// trying its isqrt(v) candidate squares through the one read port of the
// table (one candidate square per cycle). Once a value is in the table its
// walk reads and then presents each term, waiting out any output stall. A
// new target is taken only while the block is idle; a pending output may
// still be waiting then.
// Depends on msd_pkg and msd_table_ram.
`default_nettype none

module min_square_sum_decomposer_top #(
    parameter int MAX_VALUE = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // input channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [msd_pkg::TermW-1:0]    i_target,
    // output channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [msd_pkg::TermW-1:0]   o_square_term,
    output logic [msd_pkg::RootW-1:0]   o_term_root,
    output logic [msd_pkg::CountW-1:0]  o_term_count,
    output logic                        o_last_term
);

    // The target port is 11 bits, so nothing above 2047 can ever be asked.
    localparam int Limit = (MAX_VALUE < 2047) ? MAX_VALUE : 2047;
    localparam int Depth = Limit + 1;
    localparam int AW    = $clog2(Depth);
    localparam int XW    = AW + 1;      // room for (root+1)^2 past the limit
    localparam int RW    = msd_pkg::RootW;
    localparam int CW    = msd_pkg::CountW;
    localparam int EW    = msd_pkg::EmitW;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    msd_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_fill,  n_fill;     // highest value in the table
    logic [RW-1:0]      r_root,  n_root;     // isqrt(r_fill)
    logic [XW-1:0]      r_nsq,   n_nsq;      // (r_root + 1)^2
    logic               r_rd_vld, n_rd_vld;  // fill read in flight
    logic               r_out_vld, n_out_vld;

    logic [AW-1:0]      r_n,      n_n;       // saturated target
    logic [AW-1:0]      r_v,      n_v;       // value being filled
    logic [RW-1:0]      r_root_v, n_root_v;  // isqrt(r_v)
    logic [RW-1:0]      r_k,      n_k;       // candidate root
    logic [XW-1:0]      r_sq,     n_sq;      // r_k squared
    logic [RW-1:0]      r_rd_k,   n_rd_k;    // root of the read in flight
    logic [CW-1:0]      r_best,   n_best;
    logic [RW-1:0]      r_best_k, n_best_k;
    logic [AW-1:0]      r_cur,    n_cur;     // walk position
    logic [EW-1:0]      r_emit,   n_emit;    // terms emitted so far
    logic [CW-1:0]      r_count,  n_count;

    logic [msd_pkg::TermW-1:0]  r_o_term,  n_o_term;
    logic [RW-1:0]              r_o_root,  n_o_root;
    logic [CW-1:0]              r_o_count, n_o_count;
    logic                       r_o_last,  n_o_last;

    // ---------------------------------------------------------------
    // Table memory
    // ---------------------------------------------------------------
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_raddr;
    msd_pkg::t_entry    ram_wdata, ram_rdata;

    msd_table_ram #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_v),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    logic [AW-1:0]      tgt_sat;
    logic [AW-1:0]      v_next;
    logic               v_is_sq;
    logic [CW-1:0]      cand;
    logic [2*RW-1:0]    kk;
    logic [AW-1:0]      pred;
    logic               last;
    logic [CW-1:0]      run_count;
    logic               out_free;

    always_comb begin
        tgt_sat   = (int'(i_target) > Limit) ? AW'(Limit) : AW'(i_target);
        v_next    = r_fill + AW'(1);
        v_is_sq   = (XW'(v_next) == r_nsq);
        cand      = ram_rdata.count + CW'(1);
        kk        = ram_rdata.root * ram_rdata.root;
        pred      = r_cur - AW'(kk);
        last      = (pred == '0) || (r_emit == msd_pkg::EmitLast);
        run_count = (r_emit == '0) ? ram_rdata.count : r_count;
        out_free  = !r_out_vld || !i_out_stall;

        n_state   = r_state;
        n_fill    = r_fill;
        n_root    = r_root;
        n_nsq     = r_nsq;
        n_rd_vld  = r_rd_vld;
        n_out_vld = r_out_vld;
        n_n       = r_n;
        n_v       = r_v;
        n_root_v  = r_root_v;
        n_k       = r_k;
        n_sq      = r_sq;
        n_rd_k    = r_rd_k;
        n_best    = r_best;
        n_best_k  = r_best_k;
        n_cur     = r_cur;
        n_emit    = r_emit;
        n_count   = r_count;
        n_o_term  = r_o_term;
        n_o_root  = r_o_root;
        n_o_count = r_o_count;
        n_o_last  = r_o_last;

        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = r_cur;
        ram_wdata.count = r_best;
        ram_wdata.root  = r_best_k;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            msd_pkg::StIdle: begin
                if (i_in_valid && (i_target != '0)) begin
                    n_n    = tgt_sat;
                    n_cur  = tgt_sat;
                    n_emit = '0;
                    if (tgt_sat > r_fill) begin
                        n_state = msd_pkg::StFillStart;
                    end else begin
                        n_state = msd_pkg::StWalkRd;
                    end
                end
            end

            msd_pkg::StFillStart: begin
                n_v      = v_next;
                n_k      = msd_pkg::RootOne;
                n_sq     = XW'(1);
                n_best   = msd_pkg::CountNone;
                n_rd_vld = 1'b0;
                if (v_is_sq) begin
                    // exact square: one term, no search
                    n_root_v = r_root + msd_pkg::RootOne;
                    n_best   = msd_pkg::CountOne;
                    n_best_k = r_root + msd_pkg::RootOne;
                    n_state  = msd_pkg::StFillWr;
                end else begin
                    n_root_v = r_root;
                    n_state  = msd_pkg::StFill;
                end
            end

            msd_pkg::StFill: begin
                // strict compare in ascending k: smallest root wins a tie
                if (r_rd_vld && (cand < r_best)) begin
                    n_best   = cand;
                    n_best_k = r_rd_k;
                end
                if (r_k <= r_root_v) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_v - AW'(r_sq);
                    n_rd_k    = r_k;
                    n_rd_vld  = 1'b1;
                    n_k       = r_k + msd_pkg::RootOne;
                    n_sq      = r_sq + (XW'(r_k) << 1) + XW'(1);
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = msd_pkg::StFillWr;
                    end
                end
            end

            msd_pkg::StFillWr: begin
                ram_we = 1'b1;
                n_fill = r_v;
                n_root = r_root_v;
                if (r_root_v != r_root) begin
                    n_nsq = r_nsq + (XW'(r_root_v) << 1) + XW'(1);
                end
                if (r_v == r_n) begin
                    n_state = msd_pkg::StWalkRd;
                end else begin
                    n_state = msd_pkg::StFillStart;
                end
            end

            msd_pkg::StWalkRd: begin
                ram_re    = 1'b1;
                ram_raddr = r_cur;
                n_state   = msd_pkg::StWalkOut;
            end

            msd_pkg::StWalkOut: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_o_term  = msd_pkg::TermW'(kk);
                    n_o_root  = ram_rdata.root;
                    n_o_count = run_count;
                    n_o_last  = last;
                    n_count   = run_count;
                    n_cur     = pred;
                    n_emit    = r_emit + EW'(1);
                    n_state   = last ? msd_pkg::StIdle : msd_pkg::StWalkRd;
                end
            end

            default: begin
                n_state = msd_pkg::StIdle;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msd_pkg::StIdle;
            r_fill    <= '0;
            r_root    <= '0;
            r_nsq     <= XW'(1);
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_root    <= n_root;
            r_nsq     <= n_nsq;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_v       <= n_v;
        r_root_v  <= n_root_v;
        r_k       <= n_k;
        r_sq      <= n_sq;
        r_rd_k    <= n_rd_k;
        r_best    <= n_best;
        r_best_k  <= n_best_k;
        r_cur     <= n_cur;
        r_emit    <= n_emit;
        r_count   <= n_count;
        r_o_term  <= n_o_term;
        r_o_root  <= n_o_root;
        r_o_count <= n_o_count;
        r_o_last  <= n_o_last;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_in_stall    = (r_state != msd_pkg::StIdle);
    assign o_out_valid   = r_out_vld;
    assign o_square_term = r_o_term;
    assign o_term_root   = r_o_root;
    assign o_term_count  = r_o_count;
    assign o_last_term   = r_o_last;

endmodule

`default_nettype wire

>>> hw/rtl/msd_table_ram.sv
// Table memory: one write port, one read port, registered read data.
// Depends on msd_pkg (t_entry).
`default_nettype none

module msd_table_ram #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  wire msd_pkg::t_entry i_wdata,
    input  wire                  i_re,
    input  wire [AW-1:0]         i_raddr,
    output msd_pkg::t_entry      o_rdata
);

    msd_pkg::t_entry r_mem [DEPTH];
    msd_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> bench/msd_checker.sv
// Scoreboard for the minimum square-sum decomposer: watches both channels, predicts the
// square terms of every accepted target and compares them with the output transactions.
// Depends on msd_pkg for field widths.
`default_nettype none

module msd_checker #(
    parameter int MaxValue = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_stall,
    input  wire [msd_pkg::TermW-1:0]    i_target,
    input  wire                         i_out_valid,
    input  wire                         i_out_stall,
    input  wire [msd_pkg::TermW-1:0]    i_square_term,
    input  wire [msd_pkg::RootW-1:0]    i_term_root,
    input  wire [msd_pkg::CountW-1:0]   i_term_count,
    input  wire                         i_last_term,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [msd_pkg::TermW-1:0]  square;
        logic [msd_pkg::RootW-1:0]  root;
        logic [msd_pkg::CountW-1:0] count;
        logic                       last;
    } t_term;

    // Model tables: least count and the value left once the chosen square is taken off.
    logic [msd_pkg::CountW-1:0] least_count [0:MaxValue];
    int unsigned                remainder_of [0:MaxValue];
    int unsigned                filled_to;
    t_term                      pending_terms [$];
    int                         fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        filled_to    = 0;
    end

    function automatic int unsigned isqrt(int unsigned v);
        int unsigned r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
        fails++;
    endtask

    // Extend the tables up to the target, then walk the remainders and queue one term each.
    task automatic decompose(logic [msd_pkg::TermW-1:0] raw);
        int unsigned n;
        int unsigned v;
        int unsigned root;
        int unsigned best;
        int unsigned best_rest;
        int unsigned c;
        int unsigned cur;
        int unsigned rest;
        int unsigned term;
        int unsigned count;
        t_term       t;
        n = raw;
        if (n == 0)
            return;
        if (n > MaxValue)
            n = MaxValue;
        if (n > filled_to) begin
            root = isqrt(filled_to + 1);
            for (v = filled_to + 1; v <= n; v++) begin
                while ((root + 1) * (root + 1) <= v)
                    root++;
                if (root * root == v) begin
                    least_count[v]  = msd_pkg::CountOne;
                    remainder_of[v] = 0;
                end else begin
                    best      = 32'hFFFF_FFFF;
                    best_rest = v - 1;
                    // strict compare in ascending k: smallest root wins a tie
                    for (int unsigned k = 1; k <= root; k++) begin
                        c = least_count[v - k * k] + 1;
                        if (c < best) begin
                            best      = c;
                            best_rest = v - k * k;
                        end
                    end
                    least_count[v]  = msd_pkg::CountW'(best);
                    remainder_of[v] = best_rest;
                end
            end
            filled_to = n;
        end
        count = least_count[n];
        cur   = n;
        for (int i = 0; i < 4 && cur != 0; i++) begin
            rest = remainder_of[cur];
            if (rest > cur)
                rest = 0;
            term     = cur - rest;
            t.square = msd_pkg::TermW'(term);
            t.root   = msd_pkg::RootW'(isqrt(term));
            t.count  = msd_pkg::CountW'(count);
            t.last   = (rest == 0 || i == 3);
            pending_terms.push_back(t);
            cur = rest;
        end
    endtask

    always @(posedge i_clk) begin
        t_term want;
        if (!i_rst_n) begin
            filled_to = 0;
            pending_terms.delete();
        end else begin
            // a term leaving at this edge belongs to an earlier target than one taken now
            if (i_out_valid && !i_out_stall) begin
                if (pending_terms.size() == 0) begin
                    report_mismatch("unexpected square_term", i_square_term, 0);
                end else begin
                    want = pending_terms.pop_front();
                    if (i_square_term !== want.square)
                        report_mismatch("square_term", i_square_term, want.square);
                    if (i_term_root !== want.root)
                        report_mismatch("term_root", i_term_root, want.root);
                    if (i_term_count !== want.count)
                        report_mismatch("term_count", i_term_count, want.count);
                    if (i_last_term !== want.last)
                        report_mismatch("last_term", i_last_term, want.last);
                end
            end
            if (i_in_valid && !i_in_stall)
                decompose(i_target);
        end
        o_pending    <= pending_terms.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Top of the bench for min_square_sum_decomposer_top: clock, reset, target stimulus and
// output back-pressure, plus the verdict. Prediction and comparison live in msd_checker.
// Depends on msd_pkg, msd_checker and the RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxValue      = 1024;
    localparam int RandomTargets = 100;
    localparam int LongHold      = 400;   // cycles of solid output stall, once
    localparam int TailCycles    = 32;
    // Slowest legal run: the table fill, plus ~130 targets each waiting out
    // sender gaps and up to four heavily stalled terms, plus the long hold. Ten-fold margin.
    localparam int CycleLimit    = 400_000;

    typedef enum int {
        StallNone,
        StallLight,
        StallHeavy
    } t_stall_mode;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic [msd_pkg::TermW-1:0]  target    = '0;
    logic                       out_stall = 1'b0;
    logic                       in_stall;
    logic                       out_valid;
    logic [msd_pkg::TermW-1:0]  square_term;
    logic [msd_pkg::RootW-1:0]  term_root;
    logic [msd_pkg::CountW-1:0] term_count;
    logic                       last_term;

    int                 fail_count;
    int                 pending;
    int                 cycles        = 0;
    int                 burst_left    = 0;
    logic               hold_request  = 1'b0;

    // receiver-side state, owned by the stall process alone
    int                 hold_left     = 0;
    bit                 hold_done     = 1'b0;
    int                 mode_left     = 0;
    t_stall_mode        stall_mode    = StallNone;

    min_square_sum_decomposer_top #(
        .MAX_VALUE (MaxValue)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_target      (target),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_square_term (square_term),
        .o_term_root   (term_root),
        .o_term_count  (term_count),
        .o_last_term   (last_term)
    );

    msd_checker #(
        .MaxValue (MaxValue)
    ) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_target      (target),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_square_term (square_term),
        .i_term_root   (term_root),
        .i_term_count  (term_count),
        .i_last_term   (last_term),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost term ends here.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output back-pressure. Stall behaviour changes in phases: no stall at all, light
    // random stall, heavy random stall. Once asked by the stimulus, one long solid hold
    // is inserted so the block backs up and has to stall its input channel.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LongHold - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                StallNone: begin
                    out_stall <= 1'b0;
                end
                StallLight: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Offer one target and hold it until the block takes it. Targets go out in bursts;
    // between bursts valid drops for a random gap, so valid is
    // never lowered and raised within the same step. The odd long burst gives stretches
    // with no sender idling at all.
    task automatic offer_target(logic [msd_pkg::TermW-1:0] t);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid <= 1'b1;
        target   <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial begin
        // Directed: lone square, counts of two, three and four, exact squares, a value
        // already in the table (walk only), zero targets, and the table grown in small
        // and larger steps.
        logic [msd_pkg::TermW-1:0] directed [$] = '{
            0, 1, 2, 3, 4, 7, 5, 6, 12, 13, 0, 8, 15, 17, 28, 48, 50, 64, 99,
            100, 112, 128, 79, 200
        };
        int unsigned frontier;
        int unsigned pick;
        logic [msd_pkg::TermW-1:0] t;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer_target(directed[i]);

        // Random part. The table boundary climbs in random steps so filling keeps
        // happening from varied starting points; most targets are walks over the filled
        // part. Over-range targets, which saturate, join once the table is full.
        hold_request <= 1'b1;
        frontier = 200;
        repeat (RandomTargets) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                t = '0;
            end else if (pick < 7 && frontier < MaxValue) begin
                frontier = frontier + $urandom_range(1, 64);
                if (frontier > MaxValue)
                    frontier = MaxValue;
                t = msd_pkg::TermW'(frontier);
            end else if (pick < 10 && frontier == MaxValue) begin
                t = msd_pkg::TermW'($urandom_range(MaxValue + 1, 2047));
            end else if (pick < 12) begin
                t = msd_pkg::TermW'($urandom_range(1, 32));
            end else begin
                t = msd_pkg::TermW'($urandom_range(1, frontier));
            end
            offer_target(t);
        end

        // Top of the range: the limit less one, the limit, saturation just above, all-ones.
        offer_target(msd_pkg::TermW'(MaxValue - 1));
        offer_target(msd_pkg::TermW'(MaxValue));
        offer_target(msd_pkg::TermW'(MaxValue + 1));
        offer_target('1);
        in_valid <= 1'b0;

        // pending is registered in the checker, so step once before polling it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
